### design/sound_cpu_memory_map_banked_top_macros.svh
// Assertion macros for the sound CPU memory map decoder
`ifndef SOUND_CPU_MEMORY_MAP_BANKED_TOP_MACROS_SVH
`define SOUND_CPU_MEMORY_MAP_BANKED_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scm assertion failed");
`define SCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scm assertion failed");
`else
`define SCM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/scm_pkg.sv
// Types and constants shared by the sound CPU memory map decoder
`timescale 1ns / 1ps
package scm_pkg;

  localparam int unsigned CPU_ADDR_W = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned EXT_ADDR_W = 24;
  localparam int unsigned BANK_W     = 9;
  localparam int unsigned PORT_W     = 2;

  localparam logic [CPU_ADDR_W-1:0] ADDR_IO_BASE    = 16'h2000;
  localparam logic [CPU_ADDR_W-1:0] ADDR_SOUND_BASE = 16'h4000;
  localparam logic [CPU_ADDR_W-1:0] ADDR_BANK_BASE  = 16'h6000;
  localparam logic [CPU_ADDR_W-1:0] ADDR_WIN_BASE   = 16'h8000;
  localparam logic [CPU_ADDR_W-1:0] ADDR_WIN_MASK   = 16'h7FFF;
  localparam logic [CPU_ADDR_W-1:0] ADDR_PORT_MASK  = 16'h0003;

  localparam logic [EXT_ADDR_W-1:0] EXT_MAIN_RAM_BASE = 24'hFF0000;
  localparam logic [EXT_ADDR_W-1:0] EXT_ROM_END       = 24'h800000;

  localparam logic [DATA_W-1:0] OPEN_BUS_BYTE = 8'hFF;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    TGT_LOCAL    = 2'd0,
    TGT_SOUND    = 2'd1,
    TGT_MAIN_RAM = 2'd2,
    TGT_ROM      = 2'd3
  } target_t;

  typedef struct packed {
    logic                  valid;
    target_t               target;
    logic                  use_ram;
    logic [DATA_W-1:0]     rdata;
    logic [EXT_ADDR_W-1:0] ext_addr;
    logic [PORT_W-1:0]     port;
    logic                  fwd;
  } dec_t;

endpackage

### design/scm_ram.sv
// Local sound CPU RAM, one port, registered read
`timescale 1ns / 1ps
module scm_ram #(
  parameter int unsigned RAM_BYTES = 8192
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [$clog2(RAM_BYTES)-1:0] addr,
  input  logic [scm_pkg::DATA_W-1:0]   wdata,
  output logic [scm_pkg::DATA_W-1:0]   rdata_r
);
  import scm_pkg::*;

  logic [DATA_W-1:0] mem [RAM_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

### design/scm_decode.sv
// Address decode, bank register and RAM request issue
`timescale 1ns / 1ps
module scm_decode #(
  parameter int unsigned RAM_BYTES = 8192
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic                             operation,
  input  logic [scm_pkg::CPU_ADDR_W-1:0]   cpu_address,
  input  logic [scm_pkg::DATA_W-1:0]       write_data,
  output logic                             ram_we,
  output logic                             ram_re,
  output logic [$clog2(RAM_BYTES)-1:0]     ram_addr,
  output logic [scm_pkg::DATA_W-1:0]       ram_wdata,
  output scm_pkg::dec_t                    dec_r
);
  import scm_pkg::*;

  localparam int unsigned AW = $clog2(RAM_BYTES);
  localparam logic [15:0] RB1 = 16'(RAM_BYTES);
  localparam logic [15:0] RB2 = 16'(RAM_BYTES * 2);
  localparam logic [15:0] RB4 = 16'(RAM_BYTES * 4);

  logic [BANK_W-1:0]     bank_r, bank_nxt;
  dec_t                  dec_nxt;
  logic [15:0]           idx;
  logic [EXT_ADDR_W-1:0] banked;
  logic                  is_wr;

  // reduce the low window modulo the RAM size
  always_comb begin
    idx = {3'b000, cpu_address[12:0]};
    if (idx >= RB4) begin
      idx = idx - RB4;
    end
    if (idx >= RB2) begin
      idx = idx - RB2;
    end
    if (idx >= RB1) begin
      idx = idx - RB1;
    end
  end

  assign is_wr     = (op_t'(operation) == OP_WRITE);
  assign banked    = {bank_r, cpu_address[14:0]};
  assign ram_addr  = idx[AW-1:0];
  assign ram_wdata = write_data;

  always_comb begin
    dec_nxt          = '0;
    dec_nxt.valid    = accept;
    dec_nxt.target   = TGT_LOCAL;
    bank_nxt         = bank_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    if (cpu_address < ADDR_IO_BASE) begin
      ram_we          = accept && is_wr;
      ram_re          = accept && !is_wr;
      dec_nxt.use_ram = !is_wr;
    end else if (cpu_address < ADDR_SOUND_BASE) begin
      dec_nxt.rdata = is_wr ? '0 : OPEN_BUS_BYTE;
    end else if (cpu_address < ADDR_BANK_BASE) begin
      dec_nxt.target = TGT_SOUND;
      dec_nxt.port   = PORT_W'(cpu_address & ADDR_PORT_MASK);
      dec_nxt.fwd    = is_wr;
    end else if (cpu_address < ADDR_WIN_BASE) begin
      if (!is_wr) begin
        dec_nxt.rdata = OPEN_BUS_BYTE;
      end else if (cpu_address == ADDR_BANK_BASE && accept) begin
        bank_nxt = {write_data[0], bank_r[BANK_W-1:1]};
      end
    end else begin
      if (banked >= EXT_MAIN_RAM_BASE) begin
        dec_nxt.target   = TGT_MAIN_RAM;
        dec_nxt.ext_addr = banked;
        dec_nxt.fwd      = is_wr;
      end else if (!is_wr && banked < EXT_ROM_END) begin
        dec_nxt.target   = TGT_ROM;
        dec_nxt.ext_addr = banked;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= '0;
      dec_r.valid <= 1'b0;
    end else begin
      bank_r      <= bank_nxt;
      dec_r.valid <= dec_nxt.valid;
    end
    dec_r.target   <= dec_nxt.target;
    dec_r.use_ram  <= dec_nxt.use_ram;
    dec_r.rdata    <= dec_nxt.rdata;
    dec_r.ext_addr <= dec_nxt.ext_addr;
    dec_r.port     <= dec_nxt.port;
    dec_r.fwd      <= dec_nxt.fwd;
  end

endmodule

### design/sound_cpu_memory_map_banked_top.sv
// Top level of the banked sound CPU memory map decoder
`timescale 1ns / 1ps
`include "sound_cpu_memory_map_banked_top_macros.svh"
// One request is taken per clock: busy stays low. A taken request passes the
// decode register dec_r, then the output registers, and its result shows on
// the out_ ports, marked by out_valid; results keep request order. The local
// single-port RAM is read or written at the accepting edge and its registered
// read data is merged into the output registers with the decode result; a
// write is therefore seen by a read in the very next request. A bank address
// write takes effect for the next request. The receiver cannot hold it off.
module sound_cpu_memory_map_banked_top #(
  parameter int unsigned RAM_BYTES = 8192
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_operation,
  input  logic [scm_pkg::CPU_ADDR_W-1:0]     in_cpu_address,
  input  logic [scm_pkg::DATA_W-1:0]         in_write_data,
  output logic                               out_valid,
  output logic [1:0]                         out_target,
  output logic [scm_pkg::DATA_W-1:0]         out_read_data,
  output logic [scm_pkg::EXT_ADDR_W-1:0]     out_external_address,
  output logic [scm_pkg::PORT_W-1:0]         out_sound_port,
  output logic                               out_forward_write
);
  import scm_pkg::*;

  localparam int unsigned AW = $clog2(RAM_BYTES);

  logic                  accept;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_addr;
  logic [DATA_W-1:0]     ram_wdata, ram_rdata_r;
  dec_t                  dec_r;

  logic                  out_valid_r;
  target_t               out_target_r;
  logic [DATA_W-1:0]     out_read_data_r;
  logic [EXT_ADDR_W-1:0] out_ext_r;
  logic [PORT_W-1:0]     out_port_r;
  logic                  out_fwd_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  scm_decode #(.RAM_BYTES(RAM_BYTES)) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .operation  (in_operation),
    .cpu_address(in_cpu_address),
    .write_data (in_write_data),
    .ram_we     (ram_we),
    .ram_re     (ram_re),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .dec_r      (dec_r)
  );

  scm_ram #(.RAM_BYTES(RAM_BYTES)) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .re     (ram_re),
    .addr   (ram_addr),
    .wdata  (ram_wdata),
    .rdata_r(ram_rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dec_r.valid;
    end
    out_target_r    <= dec_r.target;
    out_read_data_r <= dec_r.use_ram ? ram_rdata_r : dec_r.rdata;
    out_ext_r       <= dec_r.ext_addr;
    out_port_r      <= dec_r.port;
    out_fwd_r       <= dec_r.fwd;
  end

  assign out_valid            = out_valid_r;
  assign out_target           = out_target_r;
  assign out_read_data        = out_read_data_r;
  assign out_external_address = out_ext_r;
  assign out_sound_port       = out_port_r;
  assign out_forward_write    = out_fwd_r;

  `SCM_ASSERT_NEXT(a_accept_to_decode, clk, rst_n, accept, dec_r.valid)
  `SCM_ASSERT_NEXT(a_decode_to_result, clk, rst_n, dec_r.valid, out_valid)
  `SCM_ASSERT_NOW(a_ext_only_banked, clk, rst_n, out_valid && (out_target_r == TGT_LOCAL || out_target_r == TGT_SOUND), out_external_address == '0)
  `SCM_ASSERT_NOW(a_fwd_target, clk, rst_n, out_valid && out_forward_write, out_target_r == TGT_SOUND || out_target_r == TGT_MAIN_RAM)
  `SCM_ASSERT_NOW(a_rom_low_half, clk, rst_n, out_valid && out_target_r == TGT_ROM, !out_external_address[EXT_ADDR_W-1] && !out_forward_write)

endmodule
